>>> rtl/core/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg
// Shared types and constants for the float/integer conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package fic_pkg;

  typedef enum logic [2:0] {
    MODE_L2D = 3'd0,
    MODE_L2F = 3'd1,
    MODE_F2I = 3'd2,
    MODE_D2I = 3'd3,
    MODE_F2L = 3'd4,
    MODE_D2L = 3'd5
  } mode_t;

  localparam int unsigned ModeW = 3;
  localparam int unsigned DataW = 64;
  localparam int unsigned PosW  = 6;

  localparam logic [31:0] Int32Max = 32'h7fff_ffff;
  localparam logic [31:0] Int32Min = 32'h8000_0000;
  localparam logic [63:0] Int64Max = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] Int64Min = 64'h8000_0000_0000_0000;

  // stage 1 to stage 2 payload
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             sign;
    logic             zero;     // integer source is zero
    logic [63:0]      mag;      // magnitude (int) or left aligned significand (fp)
    logic [PosW-1:0]  pos;      // leading one position or shift amount
    logic             fixed;    // fp->int result already known
    logic [63:0]      fixed_val;
  } s1_t;

  // stage 2 to stage 3 payload
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             sign;
    logic             zero;
    logic [63:0]      norm;     // normalized magnitude or shifted integer
    logic [PosW-1:0]  pos;
    logic             fixed;
    logic [63:0]      fixed_val;
  } s2_t;

endpackage
`default_nettype wire

>>> rtl/core/fic_stream_if.sv
// ----------------------------------------------------------------------------
// fic_stream_if
// Valid/ready channel carrying a payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface fic_stream_if #(parameter int unsigned W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fic_front.sv
// ----------------------------------------------------------------------------
// fic_front
// Stage 1: decode, classify fp sources, find leading one of integer sources.
// ----------------------------------------------------------------------------
`default_nettype none
module fic_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [2:0]               in_mode,
  input  wire logic [63:0]              in_op,
  output logic                          valid,
  output fic_pkg::s1_t                  q
);
  import fic_pkg::*;

  s1_t d;
  logic [63:0] imag;
  logic [PosW-1:0] lz;
  logic        is_dbl, is_64;
  logic [10:0] e;
  logic [51:0] frac;
  logic        neg;
  logic [11:0] ex;     // unbiased exponent
  logic        emax, below_one;
  logic [63:0] maxv, minv;

  // leading one search
  always_comb begin
    lz = '0;
    for (int i = 0; i < 64; i++) begin
      if (imag[i]) lz = PosW'(i);
    end
  end

  always_comb begin
    imag   = in_op[63] ? (64'd0 - in_op) : in_op;
    is_dbl = (in_mode == MODE_D2I) || (in_mode == MODE_D2L);
    is_64  = (in_mode == MODE_F2L) || (in_mode == MODE_D2L);
    if (is_dbl) begin
      e    = in_op[62:52];
      frac = in_op[51:0];
      neg  = in_op[63];
      emax = (e == 11'h7ff);
      below_one = (e < 11'd1023);
      ex   = {1'b0, e} - 12'd1023;
    end else begin
      e    = {3'd0, in_op[30:23]};
      frac = {in_op[22:0], 29'd0};
      neg  = in_op[31];
      emax = (in_op[30:23] == 8'hff);
      below_one = (in_op[30:23] < 8'd127);
      ex   = {4'd0, in_op[30:23]} - 12'd127;
    end
    maxv = is_64 ? Int64Max : {32'd0, Int32Max};
    minv = is_64 ? Int64Min : {32'd0, Int32Min};
    d = '0;
    d.mode = in_mode;
    case (in_mode)
      MODE_L2D, MODE_L2F: begin
        d.sign = in_op[63];
        d.zero = (in_op == 64'd0);
        d.mag  = imag;
        d.pos  = lz;
      end
      MODE_F2I, MODE_D2I, MODE_F2L, MODE_D2L: begin
        d.sign = neg;
        d.mag  = {1'b1, frac, 11'd0};
        d.pos  = PosW'(6'd63 - ex[5:0]);
        if (emax && frac != 52'd0) begin
          d.fixed = 1'b1;
        end else if (emax || (!below_one && ex >= (is_64 ? 12'd63 : 12'd31))) begin
          d.fixed = 1'b1;
          d.fixed_val = neg ? minv : maxv;
        end else if (below_one) begin
          d.fixed = 1'b1;
        end
      end
      default: d.fixed = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (en) valid <= in_valid;
    if (en) q <= d;
  end
endmodule
`default_nettype wire

>>> rtl/core/fic_shift.sv
// ----------------------------------------------------------------------------
// fic_shift
// Stage 2: normalize integer magnitude, or align fp significand to integer.
// ----------------------------------------------------------------------------
`default_nettype none
module fic_shift (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire fic_pkg::s1_t d,
  output logic              valid,
  output fic_pkg::s2_t      q
);
  import fic_pkg::*;

  s2_t n;

  // one barrel shift, direction by mode
  always_comb begin
    n.mode = d.mode;
    n.sign = d.sign;
    n.zero = d.zero;
    n.pos = d.pos;
    n.fixed = d.fixed;
    n.fixed_val = d.fixed_val;
    if (d.mode == MODE_L2D || d.mode == MODE_L2F)
      n.norm = d.mag << (6'd63 - d.pos);
    else
      n.norm = d.mag >> d.pos;
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (en) valid <= in_valid;
    if (en) q <= n;
  end
endmodule
`default_nettype wire

>>> rtl/core/fic_pack.sv
// ----------------------------------------------------------------------------
// fic_pack
// Stage 3: round and pack fp results, negate and mask integer results.
// ----------------------------------------------------------------------------
`default_nettype none
module fic_pack (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire fic_pkg::s2_t d,
  output logic              valid,
  output logic [63:0]       q
);
  import fic_pkg::*;

  logic [63:0] r;
  logic [53:0] sd;   // double significand plus carry
  logic [24:0] sf;
  logic        rd, rf;
  logic [10:0] ed;
  logic [7:0]  ef;
  logic [63:0] ival;

  always_comb begin
    // nearest even on the normalized magnitude
    rd = d.norm[10] && (d.norm[9:0] != 10'd0 || d.norm[11]);
    rf = d.norm[39] && (d.norm[38:0] != 39'd0 || d.norm[40]);
    sd = {1'b0, d.norm[63:11]} + {53'd0, rd};
    sf = {1'b0, d.norm[63:40]} + {24'd0, rf};
    ed = 11'(d.pos) + 11'd1023 + {10'd0, sd[53]};
    ef = 8'(d.pos) + 8'd127 + {7'd0, sf[24]};
    ival = d.sign ? (64'd0 - d.norm) : d.norm;
    r = 64'd0;
    case (d.mode)
      MODE_L2D: if (!d.zero) r = {d.sign, ed, sd[53] ? sd[52:1] : sd[51:0]};
      MODE_L2F: if (!d.zero) r = {32'd0, d.sign, ef, sf[24] ? sf[23:1] : sf[22:0]};
      MODE_F2I, MODE_D2I: r = d.fixed ? d.fixed_val : {32'd0, ival[31:0]};
      MODE_F2L, MODE_D2L: r = d.fixed ? d.fixed_val : ival;
      default: r = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (en) valid <= in_valid;
    if (en) q <= r;
  end
endmodule
`default_nettype wire

>>> rtl/core/float_integer_convert.sv
// ----------------------------------------------------------------------------
// float_integer_convert
// Integer to IEEE float/double and float/double to integer conversion.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in       sink {mode[2:0], operand_bits[63:0]}
//  out      src  result_bits[63:0]
//
// Three register stages: classify/leading one, shift, round/pack.
// One item per cycle sustained while the output accepts results.
// Synchronous reset clears the stage valid bits only.
// A stalled output holds the whole pipe, bubbles included.
`default_nettype none
module float_integer_convert (
  input  wire logic clk,
  input  wire logic rst,
  fic_stream_if.sink   in,
  fic_stream_if.source out
);
  import fic_pkg::*;

  logic v1, v2, v3;
  s1_t  q1;
  s2_t  q2;
  logic en;

  // pipe advances when the last stage is empty or drained
  assign en       = !v3 || out.ready;
  assign in.ready = en;

  fic_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in.valid),
    .in_mode(in.data[66:64]), .in_op(in.data[63:0]), .valid(v1), .q(q1)
  );
  fic_shift u_shift (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .d(q1), .valid(v2), .q(q2)
  );
  fic_pack u_pack (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .d(q2), .valid(v3),
    .q(out.data)
  );

  assign out.valid = v3;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result changed under stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready |=> v1)
    else $error("accepted item lost in stage 1");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("stall without pending result");
`endif
endmodule
`default_nettype wire
